>>> sv/btlk_pkg.sv
// Shared types and constants of the bitmap text layout block.
package btlk_pkg;

  localparam int CODES = 256;
  localparam int PAGES = 16;
  localparam int COORD_BITS = 12;
  localparam int CODE_BITS = 8;
  localparam int KERN_DEPTH = CODES * CODES;
  localparam int KERN_ADDR_BITS = 2 * CODE_BITS;
  localparam int SRC_BITS = 4 * COORD_BITS;
  localparam int PLACE_BITS = 40;

  localparam logic [1:0] CFG_SCALE = 2'd0;
  localparam logic [1:0] CFG_TRACKING = 2'd1;
  localparam logic [1:0] CFG_ORIGIN_X = 2'd2;
  localparam logic [1:0] CFG_ORIGIN_Y = 2'd3;

  typedef enum logic [1:0] {
    CMD_GLYPH,
    CMD_KERN,
    CMD_CHAR,
    CMD_START
  } cmd_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_FINISH
  } state_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [7:0]         code;
    logic [7:0]         second_code;
    logic [11:0]        src_x;
    logic [11:0]        src_y;
    logic [11:0]        glyph_width;
    logic [11:0]        glyph_height;
    logic signed [11:0] offset_x;
    logic signed [11:0] offset_y;
    logic signed [11:0] advance;
    logic [3:0]         page;
    logic signed [7:0]  kern_amount;
  } in_item_t;

  typedef struct packed {
    logic [11:0]        out_src_x;
    logic [11:0]        out_src_y;
    logic [11:0]        out_src_w;
    logic [11:0]        out_src_h;
    logic signed [31:0] dst_x;
    logic signed [31:0] dst_y;
    logic [30:0]        dst_w;
    logic [30:0]        dst_h;
    logic [3:0]         out_page;
    logic signed [31:0] pen_after;
  } out_item_t;

  typedef struct packed {
    logic [11:0] sx;
    logic [11:0] sy;
    logic [11:0] sw;
    logic [11:0] sh;
  } glyph_src_t;

  typedef struct packed {
    logic signed [11:0] ox;
    logic signed [11:0] oy;
    logic signed [11:0] adv;
    logic [3:0]         page;
  } glyph_place_t;

  typedef struct packed {
    logic [15:0]        scale;
    logic [7:0]         tracking;
    logic signed [31:0] origin_y;
    logic signed [31:0] pen;
    logic               prev_nz;
  } calc_ctx_t;

endpackage

>>> sv/btlk_ram.sv
// Generic simple dual-port RAM with registered read.
module btlk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/btlk_calc.sv
// Scaling products and signed Q24.8 pen and destination sums for one glyph.
module btlk_calc (
  input  logic                  clk,
  input  logic                  load,
  input  btlk_pkg::glyph_src_t   src,
  input  btlk_pkg::glyph_place_t place,
  input  logic signed [7:0]     kern,
  input  btlk_pkg::calc_ctx_t    ctx,
  output btlk_pkg::out_item_t    result
);

  logic signed [16:0] sscale;
  logic signed [12:0] adv_sum;
  logic signed [24:0] kprod;
  logic signed [28:0] oxprod;
  logic signed [28:0] oyprod;
  logic signed [29:0] advprod;
  logic [27:0]        wprod;
  logic [27:0]        hprod;
  btlk_pkg::glyph_src_t src_q;
  logic [3:0]         page_q;
  logic signed [31:0] kern_term;
  logic signed [31:0] pen_k;

  assign sscale = $signed({1'b0, ctx.scale});
  assign adv_sum = {place.adv[11], place.adv} + $signed({5'b0, ctx.tracking});

  always_ff @(posedge clk) begin
    if (load) begin
      kprod <= kern * sscale;
      oxprod <= place.ox * sscale;
      oyprod <= place.oy * sscale;
      advprod <= adv_sum * sscale;
      wprod <= src.sw * ctx.scale;
      hprod <= src.sh * ctx.scale;
      src_q <= src;
      page_q <= place.page;
    end
  end

  always_comb begin
    kern_term = ctx.prev_nz ? {{7{kprod[24]}}, kprod} : 32'sd0;
    pen_k = ctx.pen + kern_term;
    result.out_src_x = src_q.sx;
    result.out_src_y = src_q.sy;
    result.out_src_w = src_q.sw;
    result.out_src_h = src_q.sh;
    result.dst_x = pen_k + {{3{oxprod[28]}}, oxprod};
    result.dst_y = ctx.origin_y + {{3{oyprod[28]}}, oyprod};
    result.dst_w = {3'b0, wprod};
    result.dst_h = {3'b0, hprod};
    result.out_page = page_q;
    result.pen_after = pen_k + {{2{advprod[29]}}, advprod};
  end

endmodule

>>> sv/bitmap_text_layout_kerning.sv
// Top level of the bitmap font text layout block with kerning.
// Input items arrive on item/item_valid/item_stall: glyph loads, kerning pair
// loads, characters and start-of-text items. Each character with a loaded
// glyph yields one blit command on blit/blit_valid/blit_stall; all other items
// yield nothing. Registers (scale, tracking, origin_x, origin_y) are written
// on the cfg channel, which is always ready.
// Load and start items, and characters without a glyph, leave the block idle.
// A character with a glyph passes through a read of the glyph and kerning
// memories, the scale products and the pen sums; the pen update of each
// character feeds the next one.
// The result sits in an output register, so new items are taken while a
// result waits; a character finishing while the previous result is still
// stalled holds in its last cycle until the output register frees.
// After reset the kerning memory is swept to zero, one entry a cycle, over all
// 65536 entries; item_stall stays high during the sweep while cfg writes are
// still taken. Glyph valid bits clear at once at reset.
module bitmap_text_layout_kerning (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  btlk_pkg::in_item_t  item,
  output logic                blit_valid,
  input  logic                blit_stall,
  output btlk_pkg::out_item_t blit,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  btlk_pkg::state_t state;
  btlk_pkg::state_t state_next;

  logic [15:0]        scale;
  logic [7:0]         tracking;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] pen;
  logic [7:0]         prev_code;
  logic [7:0]         code_q;
  logic [btlk_pkg::KERN_ADDR_BITS-1:0] clr_addr;
  logic [btlk_pkg::CODES-1:0] glyph_valid;

  logic accept;
  logic code_ok;
  logic page_ok;
  logic glyph_we;
  logic kern_we;
  logic kern_wr;
  logic finish;
  logic calc_load;

  logic [btlk_pkg::SRC_BITS-1:0]   src_rd;
  logic [btlk_pkg::PLACE_BITS-1:0] place_rd;
  logic [7:0]                      kern_rd;
  logic [btlk_pkg::KERN_ADDR_BITS-1:0] kern_waddr;
  logic [7:0]                      kern_wdata;
  btlk_pkg::glyph_src_t   src_wr;
  btlk_pkg::glyph_place_t place_wr;
  btlk_pkg::calc_ctx_t    ctx;
  btlk_pkg::out_item_t    result;

  assign cfg_ready = 1'b1;
  assign item_stall = (state != btlk_pkg::ST_IDLE);
  assign accept = item_valid && !item_stall;
  assign code_ok = ({1'b0, item.code} < 9'(btlk_pkg::CODES));
  assign page_ok = ({5'b0, item.page} < 9'(btlk_pkg::PAGES));
  assign glyph_we = accept && (item.cmd == btlk_pkg::CMD_GLYPH) && code_ok && page_ok;
  assign kern_wr = accept && (item.cmd == btlk_pkg::CMD_KERN) && code_ok
                   && ({1'b0, item.second_code} < 9'(btlk_pkg::CODES));
  assign kern_we = (state == btlk_pkg::ST_CLEAR) || kern_wr;
  assign kern_waddr = (state == btlk_pkg::ST_CLEAR) ? clr_addr
                                                    : {item.code, item.second_code};
  assign kern_wdata = (state == btlk_pkg::ST_CLEAR) ? 8'd0 : item.kern_amount;
  assign finish = (state == btlk_pkg::ST_FINISH) && (!blit_valid || !blit_stall);
  assign calc_load = (state == btlk_pkg::ST_READ);

  assign src_wr = '{sx: item.src_x, sy: item.src_y, sw: item.glyph_width,
                    sh: item.glyph_height};
  assign place_wr = '{ox: item.offset_x, oy: item.offset_y, adv: item.advance,
                      page: item.page};

  assign ctx = '{scale: scale, tracking: tracking, origin_y: origin_y, pen: pen,
                 prev_nz: (prev_code != 8'd0)};

  btlk_ram #(.WIDTH(btlk_pkg::SRC_BITS), .DEPTH(btlk_pkg::CODES)) u_src_ram (
    .clk   (clk),
    .we    (glyph_we),
    .waddr (item.code),
    .wdata (src_wr),
    .raddr (item.code),
    .rdata (src_rd)
  );

  btlk_ram #(.WIDTH(btlk_pkg::PLACE_BITS), .DEPTH(btlk_pkg::CODES)) u_place_ram (
    .clk   (clk),
    .we    (glyph_we),
    .waddr (item.code),
    .wdata (place_wr),
    .raddr (item.code),
    .rdata (place_rd)
  );

  btlk_ram #(.WIDTH(8), .DEPTH(btlk_pkg::KERN_DEPTH)) u_kern_ram (
    .clk   (clk),
    .we    (kern_we),
    .waddr (kern_waddr),
    .wdata (kern_wdata),
    .raddr ({prev_code, item.code}),
    .rdata (kern_rd)
  );

  btlk_calc u_calc (
    .clk    (clk),
    .load   (calc_load),
    .src    (btlk_pkg::glyph_src_t'(src_rd)),
    .place  (btlk_pkg::glyph_place_t'(place_rd)),
    .kern   ($signed(kern_rd)),
    .ctx    (ctx),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= btlk_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      btlk_pkg::ST_CLEAR: begin
        if (clr_addr == {btlk_pkg::KERN_ADDR_BITS{1'b1}}) begin
          state_next = btlk_pkg::ST_IDLE;
        end
      end
      btlk_pkg::ST_IDLE: begin
        if (accept && (item.cmd == btlk_pkg::CMD_CHAR) && code_ok
            && glyph_valid[item.code]) begin
          state_next = btlk_pkg::ST_READ;
        end
      end
      btlk_pkg::ST_READ: begin
        state_next = btlk_pkg::ST_FINISH;
      end
      btlk_pkg::ST_FINISH: begin
        if (finish) begin
          state_next = btlk_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = btlk_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      glyph_valid <= '0;
      pen <= 32'sd0;
      prev_code <= 8'd0;
      blit_valid <= 1'b0;
      scale <= 16'd256;
      tracking <= 8'd0;
      origin_x <= 32'sd0;
      origin_y <= 32'sd0;
    end else begin
      if (state == btlk_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (glyph_we) begin
        glyph_valid[item.code] <= 1'b1;
      end
      if (accept && (item.cmd == btlk_pkg::CMD_START)) begin
        pen <= origin_x;
        prev_code <= 8'd0;
      end
      if (finish) begin
        pen <= result.pen_after;
        prev_code <= code_q;
        blit_valid <= 1'b1;
      end else if (blit_valid && !blit_stall) begin
        blit_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          btlk_pkg::CFG_SCALE:     scale <= cfg_data[15:0];
          btlk_pkg::CFG_TRACKING:  tracking <= cfg_data[7:0];
          btlk_pkg::CFG_ORIGIN_X:  origin_x <= $signed(cfg_data);
          btlk_pkg::CFG_ORIGIN_Y:  origin_y <= $signed(cfg_data);
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      code_q <= item.code;
    end
    if (finish) begin
      blit <= result;
    end
  end

endmodule
